>>> rtl/rne_pkg.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder package
// Command and status types between controller and datapath, symbol tables
// and place-value multiples used for digit extraction.
// ----------------------------------------------------------------------------
package rne_pkg;

	localparam int unsigned VALUE_W  = 12;
	localparam int unsigned LETTER_W = 8;
	localparam int unsigned MULT_W   = 14;

	localparam logic [VALUE_W-1:0] MAX_ENCODABLE = 12'd3999;

	localparam logic [3:0] DIG_FOUR = 4'd4;
	localparam logic [3:0] DIG_FIVE = 4'd5;
	localparam logic [3:0] DIG_NINE = 4'd9;

	// Symbols per place: thousands, hundreds, tens, units
	localparam logic [LETTER_W-1:0] ONE_SYM  [0:3] = '{8'h4D, 8'h43, 8'h58, 8'h49};
	localparam logic [LETTER_W-1:0] FIVE_SYM [0:3] = '{8'h00, 8'h44, 8'h4C, 8'h56};
	localparam logic [LETTER_W-1:0] TEN_SYM  [0:3] = '{8'h00, 8'h4D, 8'h43, 8'h58};

	// k * place value, for k = 0..9
	localparam logic [MULT_W-1:0] PLACE_MULT [0:3][0:9] = '{
		'{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
		  14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000},
		'{14'd0, 14'd100, 14'd200, 14'd300, 14'd400,
		  14'd500, 14'd600, 14'd700, 14'd800, 14'd900},
		'{14'd0, 14'd10, 14'd20, 14'd30, 14'd40,
		  14'd50, 14'd60, 14'd70, 14'd80, 14'd90},
		'{14'd0, 14'd1, 14'd2, 14'd3, 14'd4,
		  14'd5, 14'd6, 14'd7, 14'd8, 14'd9}
	};

	typedef struct packed {
		logic load;
		logic extract;
		logic emit;
		logic emit_empty;
		logic next_place;
	} rne_cmd_t;

	typedef struct packed {
		logic in_bad;
		logic dig_zero;
		logic step_last;
		logic rem_zero;
	} rne_status_t;

	// Index of the final letter within one digit's run
	function automatic logic [1:0] last_step(input logic [3:0] dig);
		logic [1:0] r;
		if (dig == DIG_NINE || dig == DIG_FOUR) begin
			r = 2'd1;
		end else if (dig >= DIG_FIVE) begin
			r = 2'(dig - DIG_FIVE);
		end else if (dig == 4'd0) begin
			r = 2'd0;
		end else begin
			r = 2'(dig - 4'd1);
		end
		return r;
	endfunction

	function automatic logic [LETTER_W-1:0] letter_at(input logic [1:0] place,
		input logic [3:0] dig, input logic [1:0] step);
		logic [LETTER_W-1:0] s;
		s = ONE_SYM[place];
		if (dig == DIG_NINE) begin
			if (step != 2'd0) s = TEN_SYM[place];
		end else if (dig == DIG_FOUR) begin
			if (step != 2'd0) s = FIVE_SYM[place];
		end else if (dig >= DIG_FIVE && step == 2'd0) begin
			s = FIVE_SYM[place];
		end
		return s;
	endfunction

endpackage

>>> rtl/rne_datapath.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder datapath
// Holds the remainder, place and digit, extracts one decimal digit per
// extract command and loads the output register with one letter per emit.
// ----------------------------------------------------------------------------
module rne_datapath
	import rne_pkg::*;
(
	input  logic                clk,
	input  logic [VALUE_W-1:0]  value,
	input  rne_cmd_t            cmd,
	output rne_status_t         status,
	output logic [LETTER_W-1:0] letter,
	output logic                last_of_run,
	output logic                no_symbols
);

	logic [VALUE_W-1:0]  rem_q;
	logic [1:0]          place_q;
	logic [3:0]          dig_q;
	logic [1:0]          step_q;
	logic [LETTER_W-1:0] letter_q;
	logic                last_q;
	logic                empty_q;

	logic [3:0]          dig_c;
	logic [VALUE_W-1:0]  rem_next;

	// Largest k with k * place <= remainder
	always_comb begin
		dig_c = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if ({2'b00, rem_q} >= PLACE_MULT[place_q][k]) dig_c = 4'(k);
		end
		rem_next = rem_q - PLACE_MULT[place_q][dig_c][VALUE_W-1:0];
	end

	always_comb begin
		status.in_bad    = (value == '0) || (value > MAX_ENCODABLE);
		status.dig_zero  = (dig_c == 4'd0);
		status.step_last = (step_q == last_step(dig_q));
		status.rem_zero  = (rem_q == '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q   <= value;
			place_q <= 2'd0;
		end
		if (cmd.extract) begin
			rem_q  <= rem_next;
			dig_q  <= dig_c;
			step_q <= 2'd0;
		end
		if (cmd.emit) begin
			letter_q <= letter_at(place_q, dig_q, step_q);
			last_q   <= status.step_last && status.rem_zero;
			empty_q  <= 1'b0;
			step_q   <= step_q + 2'd1;
		end
		if (cmd.emit_empty) begin
			letter_q <= '0;
			last_q   <= 1'b1;
			empty_q  <= 1'b1;
		end
		if (cmd.next_place) begin
			place_q <= place_q + 2'd1;
		end
	end

	assign letter      = letter_q;
	assign last_of_run = last_q;
	assign no_symbols  = empty_q;

endmodule

>>> rtl/rne_ctrl.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder controller
// Sequences load, digit extraction and letter emission, and owns the
// input ready and output valid handshake.
// ----------------------------------------------------------------------------
module rne_ctrl
	import rne_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  rne_status_t status,
	output rne_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_EXTRACT = 2'd1;
	localparam logic [1:0] ST_EMIT    = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = status.in_bad ? ST_EMPTY : ST_EXTRACT;
				end
			end
			ST_EXTRACT: begin
				cmd.extract = 1'b1;
				// skip a zero digit and move on to the next place
				if (status.dig_zero) begin
					cmd.next_place = 1'b1;
				end else begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					if (status.step_last) begin
						if (status.rem_zero) begin
							state_next = ST_IDLE;
						end else begin
							cmd.next_place = 1'b1;
							state_next     = ST_EXTRACT;
						end
					end
				end
			end
			ST_EMPTY: begin
				if (slot_free) begin
					cmd.emit_empty = 1'b1;
					state_next     = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit || cmd.emit_empty) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// an output transaction is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_empty) |-> (!out_valid_q || out_ready))
		else $error("output register loaded while holding an untaken letter");

	// an unencodable value goes straight to the empty result
	a_bad_to_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && status.in_bad) |=> (state_q == ST_EMPTY))
		else $error("unencodable value did not produce an empty result");

	// extraction only runs while letters remain to be produced
	a_extract_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXTRACT) |-> !status.rem_zero)
		else $error("digit extraction with zero remainder");

	// a zero digit never reaches the emit state
	a_emit_after_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXTRACT && status.dig_zero) |=> (state_q == ST_EXTRACT))
		else $error("zero digit left the extract state");

endmodule

>>> rtl/roman_numeral_encoder_unit.sv
// The first letter follows the input transaction once any leading zero digits
// (at most 3) have been skipped in the extract state.
// A new input is taken only after the last letter of the previous value; the
// output register takes one letter per cycle at most, and waits on out_ready.
// An unencodable value yields one empty result.
// Reset (arst_n low) clears the controller state and output valid at once.
// ----------------------------------------------------------------------------
// Roman numeral encoder unit
// Converts a 12-bit number into its Roman numeral, one ASCII letter per
// output transaction, flagging the last letter and the empty result.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_unit
	import rne_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [LETTER_W-1:0] letter,
	output logic                last_of_run,
	output logic                no_symbols
);

	rne_cmd_t    cmd;
	rne_status_t status;

	rne_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rne_datapath u_datapath (
		.clk         (clk),
		.value       (value),
		.cmd         (cmd),
		.status      (status),
		.letter      (letter),
		.last_of_run (last_of_run),
		.no_symbols  (no_symbols)
	);

endmodule
